/* hdl/kmc_pkg.sv */
// Shared types and constants of the k-means clustering engine.
// No dependencies; imported by every module of the engine but the point store.
`timescale 1ns / 1ps
package kmc_pkg;

	localparam int COORD_W   = 16;
	localparam int DIST_W    = 34;
	localparam int ROOT_W    = 17;
	localparam int TOTAL_W   = 27;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef enum logic [1:0] {
		OP_LOAD_POINT  = 2'd0,
		OP_LOAD_CENTER = 2'd1,
		OP_RUN         = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POINT_COUNT     = 2'd0,
		CFG_DIMENSION_COUNT = 2'd1,
		CFG_CLUSTER_COUNT   = 2'd2,
		CFG_ROUND_COUNT     = 2'd3
	} cfg_idx_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_START = 10'b0000000010,
		S_PREAD = 10'b0000000100,
		S_DIST  = 10'b0000001000,
		S_ACCUM = 10'b0000010000,
		S_UPD   = 10'b0000100000,
		S_DIVW  = 10'b0001000000,
		S_SQRT  = 10'b0010000000,
		S_SQRTW = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

/* hdl/kmc_point_mem.sv */
// Point store: single-port-write, registered-read synchronous memory.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module kmc_point_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/kmc_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses the unit control struct from kmc_pkg.
`timescale 1ns / 1ps
module kmc_divider import kmc_pkg::*; #(
	parameter int NUM_W = 27,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output unit_ctl_t        ctl,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W+1:0] trial;
	logic             fits;

	assign trial = {rem_q, q_q[NUM_W-1]};
	assign fits  = trial >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			q_q   <= {q_q[NUM_W-2:0], fits};
			rem_q <= fits ? (DEN_W+1)'(trial - {2'b00, den_q}) : trial[DEN_W:0];
		end
	end

	assign ctl.start = start;
	assign ctl.done  = done_q;
	assign quot      = q_q;

endmodule

/* hdl/kmc_isqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Uses widths and the unit control struct from kmc_pkg.
`timescale 1ns / 1ps
module kmc_isqrt import kmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] value,
	output unit_ctl_t         ctl,
	output logic [ROOT_W-1:0] root
);

	localparam int RW = ROOT_W + 3;
	localparam int CW = $clog2(ROOT_W + 1);

	logic [DIST_W-1:0] val_q;
	logic [RW-1:0]     rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [RW-1:0]     rem_next;
	logic [RW-1:0]     trial;
	logic              fits;

	assign rem_next = {rem_q[RW-3:0], val_q[DIST_W-1:DIST_W-2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign fits     = rem_next >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= {val_q[DIST_W-3:0], 2'b00};
			rem_q  <= fits ? rem_next - trial : rem_next;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign ctl.start = start;
	assign ctl.done  = done_q;
	assign root      = root_q;

endmodule

/* hdl/kmeans_cluster_engine_core.sv */
// Lloyd k-means engine. Load items are taken only while idle. Distances are summed
// serially over the dimensions, new centers come from a bit-serial divider and the
// distances to the best centers from a bit-serial square root; an empty cluster skips
// the divider and has its center set to zero. One run at a time.
// Reset is asynchronous: control and the output valid are cleared, configuration is set
// to its defaults, the point and center stores stay undefined until written.
`timescale 1ns / 1ps
module kmeans_cluster_engine_core import kmc_pkg::*; #(
	parameter int MAX_POINTS   = 1024,
	parameter int MAX_DIMS     = 4,
	parameter int MAX_CLUSTERS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [9:0]            slot,
	input  logic signed [15:0]    coord_0,
	input  logic signed [15:0]    coord_1,
	input  logic signed [15:0]    coord_2,
	input  logic signed [15:0]    coord_3,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            cluster_id,
	output logic signed [15:0]    center_0,
	output logic signed [15:0]    center_1,
	output logic signed [15:0]    center_2,
	output logic signed [15:0]    center_3,
	output logic [10:0]           member_count,
	output logic [TOTAL_W-1:0]    total_distance,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	localparam int PA_W  = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int DIM_W = $clog2(MAX_DIMS + 1);
	localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CI_W  = $clog2(MAX_CLUSTERS);
	localparam int SUM_W = COORD_W + 1 + PA_W;
	localparam int PW    = MAX_DIMS * COORD_W;

	state_t state_q;
	logic [10:0] point_count_q;
	logic [2:0]  dimension_count_q;
	logic [3:0]  cluster_count_q;
	logic [7:0]  round_count_q;

	logic [CNT_W-1:0] n_eff;
	logic [DIM_W-1:0] dims_eff;
	logic [CI_W-1:0]  km1;

	logic [7:0]         r_q;
	logic [CNT_W-1:0]   p_q;
	logic [CI_W-1:0]    c_q;
	logic [DIM_W-1:0]   d_q;
	logic [DIST_W-1:0]  acc_q;
	logic [DIST_W-1:0]  best_q;
	logic [CI_W-1:0]    bidx_q;
	logic               final_q;
	logic [TOTAL_W-1:0] total_q;

	logic signed [COORD_W-1:0] center_q [MAX_CLUSTERS][MAX_DIMS];
	logic signed [SUM_W-1:0]   sum_q    [MAX_CLUSTERS][MAX_DIMS];
	logic [CNT_W-1:0]          cnt_q    [MAX_CLUSTERS];

	logic          accept_in;
	op_t           op_in;
	logic [15:0]   coord_in [4];
	logic          pm_wr;
	logic          pm_rd;
	logic [PW-1:0] pm_wdata;
	logic [PW-1:0] pm_rdata;

	logic [DI_W-1:0]            di;
	logic signed [COORD_W:0]    diff;
	logic signed [2*COORD_W+1:0] sq;
	logic [CI_W-1:0]            row;
	logic signed [SUM_W-1:0]    sum_sel;
	logic                       sum_neg;
	logic [SUM_W-1:0]           sum_mag;
	logic [SUM_W-1:0]           quot;
	logic [SUM_W-1:0]           quot_signed;
	logic                       div_start;
	logic                       sqrt_start;
	unit_ctl_t                  div_ctl;
	unit_ctl_t                  sqrt_ctl;
	logic [ROOT_W-1:0]          root;
	logic [TOTAL_W:0]           total_sum;
	logic                       clr_round;
	logic                       out_load;
	logic signed [15:0]         center_out [4];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign op_in     = op_t'(op);
	assign coord_in[0] = coord_0;
	assign coord_in[1] = coord_1;
	assign coord_in[2] = coord_2;
	assign coord_in[3] = coord_3;

	always_comb begin
		n_eff = (int'(point_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(point_count_q);
		dims_eff = (int'(dimension_count_q) > MAX_DIMS) ? DIM_W'(MAX_DIMS)
			: DIM_W'(dimension_count_q);
		if (int'(cluster_count_q) > MAX_CLUSTERS) begin
			km1 = CI_W'(MAX_CLUSTERS - 1);
		end else if (cluster_count_q == 4'd0) begin
			km1 = '0;
		end else begin
			km1 = CI_W'(cluster_count_q - 4'd1);
		end
	end

	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			pm_wdata[d*COORD_W +: COORD_W] = coord_in[d];
		end
	end

	assign pm_wr = accept_in && (op_in == OP_LOAD_POINT) && (int'(slot) < MAX_POINTS);
	assign pm_rd = (state_q == S_PREAD) && (p_q != n_eff);

	kmc_point_mem #(
		.DEPTH(MAX_POINTS),
		.WIDTH(PW),
		.AW   (PA_W)
	) u_point_mem (
		.clk    (clk),
		.wr_en  (pm_wr),
		.wr_addr(PA_W'(slot)),
		.wr_data(pm_wdata),
		.rd_en  (pm_rd),
		.rd_addr(p_q[PA_W-1:0]),
		.rd_data(pm_rdata)
	);

	assign di   = d_q[DI_W-1:0];
	assign diff = (COORD_W+1)'($signed(pm_rdata[di*COORD_W +: COORD_W]))
		- (COORD_W+1)'(center_q[c_q][di]);
	assign sq   = diff * diff;

	assign row     = (state_q == S_ACCUM) ? bidx_q : c_q;
	assign sum_sel = sum_q[row][di];
	assign sum_neg = sum_sel[SUM_W-1];
	assign sum_mag = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
	assign quot_signed = sum_neg ? SUM_W'(-quot) : quot;

	assign div_start  = (state_q == S_UPD) && (d_q < dims_eff) && (cnt_q[c_q] != '0);
	assign sqrt_start = (state_q == S_SQRT);

	kmc_divider #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_mag),
		.den   (cnt_q[c_q]),
		.ctl   (div_ctl),
		.quot  (quot)
	);

	kmc_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.value (best_q),
		.ctl   (sqrt_ctl),
		.root  (root)
	);

	assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(root);
	assign clr_round = ((state_q == S_START) && (round_count_q != 8'd0))
		|| ((state_q == S_UPD) && (d_q >= dims_eff) && (c_q == km1)
		&& (r_q + 8'd1 != round_count_q));
	assign out_load  = (state_q == S_OUT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q     <= 11'd1024;
			dimension_count_q <= 3'd4;
			cluster_count_q   <= 4'd8;
			round_count_q     <= 8'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_POINT_COUNT:     point_count_q     <= cfg_data;
				CFG_DIMENSION_COUNT: dimension_count_q <= cfg_data[2:0];
				CFG_CLUSTER_COUNT:   cluster_count_q   <= cfg_data[3:0];
				CFG_ROUND_COUNT:     round_count_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			p_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept_in && op_in == OP_RUN) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					r_q     <= '0;
					p_q     <= '0;
					final_q <= (round_count_q == 8'd0);
					state_q <= S_PREAD;
				end
				S_PREAD: begin
					c_q <= '0;
					d_q <= '0;
					if (p_q == n_eff) begin
						state_q <= final_q ? S_OUT : S_UPD;
					end else begin
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					if (d_q < dims_eff) begin
						d_q <= d_q + 1'b1;
					end else begin
						d_q <= '0;
						if (c_q == km1) begin
							state_q <= final_q ? S_SQRT : S_ACCUM;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				S_ACCUM: begin
					p_q     <= p_q + 1'b1;
					state_q <= S_PREAD;
				end
				S_UPD: begin
					if (d_q < dims_eff) begin
						if (cnt_q[c_q] == '0) begin
							d_q <= d_q + 1'b1;
						end else begin
							state_q <= S_DIVW;
						end
					end else begin
						d_q <= '0;
						if (c_q == km1) begin
							c_q     <= '0;
							p_q     <= '0;
							r_q     <= r_q + 8'd1;
							final_q <= (r_q + 8'd1 == round_count_q);
							state_q <= S_PREAD;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				S_DIVW: begin
					if (div_ctl.done) begin
						d_q     <= d_q + 1'b1;
						state_q <= S_UPD;
					end
				end
				S_SQRT: begin
					state_q <= S_SQRTW;
				end
				S_SQRTW: begin
					if (sqrt_ctl.done) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_PREAD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (c_q == km1) begin
							state_q <= S_IDLE;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PREAD) begin
			acc_q <= '0;
		end else if (state_q == S_DIST) begin
			if (d_q < dims_eff) begin
				acc_q <= acc_q + DIST_W'($unsigned(sq));
			end else begin
				acc_q <= '0;
				if (c_q == '0 || acc_q < best_q) begin
					best_q <= acc_q;
					bidx_q <= c_q;
				end
			end
		end
		if (state_q == S_START || (state_q == S_UPD && d_q >= dims_eff && c_q == km1
			&& r_q + 8'd1 == round_count_q)) begin
			total_q <= '0;
		end else if (state_q == S_SQRTW && sqrt_ctl.done) begin
			total_q <= (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && op_in == OP_LOAD_CENTER && int'(slot) < MAX_CLUSTERS) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				center_q[CI_W'(slot)][d] <= coord_in[d];
			end
		end else if (state_q == S_UPD && d_q < dims_eff && cnt_q[c_q] == '0) begin
			center_q[c_q][di] <= '0;
		end else if (state_q == S_DIVW && div_ctl.done) begin
			center_q[c_q][di] <= quot_signed[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_START) begin
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (clr_round) begin
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (state_q == S_ACCUM) begin
			cnt_q[row] <= cnt_q[row] + 1'b1;
		end
		if (clr_round) begin
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				for (int d = 0; d < MAX_DIMS; d++) begin
					sum_q[c][d] <= '0;
				end
			end
		end else if (state_q == S_ACCUM) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				sum_q[row][d] <= sum_q[row][d]
					+ SUM_W'($signed(pm_rdata[d*COORD_W +: COORD_W]));
			end
		end
	end

	always_comb begin
		for (int d = 0; d < 4; d++) begin
			if (d < MAX_DIMS && d < int'(dims_eff)) begin
				center_out[d] = center_q[c_q][DI_W'(d)];
			end else begin
				center_out[d] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cluster_id     <= 3'(c_q);
			center_0       <= center_out[0];
			center_1       <= center_out[1];
			center_2       <= center_out[2];
			center_3       <= center_out[3];
			member_count   <= 11'(cnt_q[c_q]);
			total_distance <= (c_q == km1) ? total_q : '0;
			last           <= (c_q == km1);
		end
	end

endmodule

/* hdl/kmc_checker.sv */
// Port-level checks of the k-means engine, bound to the top level.
// Depends on kmc_pkg and kmeans_cluster_engine_core.
`timescale 1ns / 1ps
module kmc_checker import kmc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         op,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         cluster_id,
	input logic [TOTAL_W-1:0] total_distance,
	input logic               last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cluster_id) && $stable(last))
		else $error("stalled result item changed");

	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> total_distance == '0)
		else $error("distance sum shown on an item that is not last");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_RUN |=> in_stall)
		else $error("input taken right after a run item");

	a_first_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid || cluster_id == 3'd0)
		else $error("new run does not start at cluster zero");

endmodule

bind kmeans_cluster_engine_core kmc_checker u_kmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.op            (op),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cluster_id    (cluster_id),
	.total_distance(total_distance),
	.last          (last)
);
